/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* rtl/core/ffca_pkg.sv */
// Types and constants for the first-fit coalescing allocator.
package ffca_pkg;
    localparam int unsigned TableEntries = 1024;
    localparam logic [31:0] PageAdd  = 32'h0000_0fff;
    localparam logic [31:0] PageMask = 32'hffff_f000;

    localparam logic OpAlloc = 1'b0;
    localparam logic OpFree  = 1'b1;

    localparam logic [1:0] StOk     = 2'd0;
    localparam logic [1:0] StNoFit  = 2'd1;
    localparam logic [1:0] StLost   = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [31:0] region_addr;
        logic [31:0] region_size;
        logic        page_round;
    } ffca_in_t;

    typedef struct packed {
        logic [31:0] alloc_addr;
        logic [1:0]  status;
        logic [31:0] free_total;
        logic [10:0] entries_used;
        logic [10:0] peak_entries;
        logic [31:0] lost_count;
        logic [31:0] lost_bytes;
    } ffca_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,   // issue read of entry idx
        ST_SCAN_CHK,  // data of entry idx available
        ST_PREV_CHK,  // data of entry k-1 available (free)
        ST_DEL_RD,    // shift down: read idx+1
        ST_DEL_WR,
        ST_INS_RD,    // shift up: read end-1
        ST_INS_WR,
        ST_RESP
    } ffca_state_t;
endpackage

/* rtl/core/first_fit_coalescing_allocator.sv */
// Top level of the first-fit coalescing free-region allocator.
//  channel | dir | handshake            | payload
//  s_      | in  | s_valid / s_ready    | ffca_pkg::ffca_in_t  s_data
//  m_      | out | m_valid / m_ready    | ffca_pkg::ffca_out_t m_data
// One word at a time; the table lives in one memory with a registered read.
// Allocate: scan for the first fit, shift entries down when one is removed.
// Free: scan for the upper neighbour, fetch the lower neighbour, shift entries
// down on merge-removal or up on insert. Reset clears state, valid flag and
// counters only; a new word is taken while the last result still waits in
// m_data, and its own result is held until that one has gone.
`include "assert_macros.svh"
module first_fit_coalescing_allocator #(
    parameter int unsigned TABLE_ENTRIES = ffca_pkg::TableEntries
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffca_pkg::ffca_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ffca_pkg::ffca_out_t m_data
);
    localparam int unsigned IW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = IW + 1;
    localparam logic [CW-1:0] Full = CW'(TABLE_ENTRIES);

    // table memory: {start, length}
    logic [63:0] mem [TABLE_ENTRIES];
    logic [63:0] rd_data;
    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [63:0]   wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    ffca_pkg::ffca_state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;       // scan position / k
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] peak_reg, peak_next;
    logic [31:0]   dcnt_reg, dcnt_next;
    logic [31:0]   dbytes_reg, dbytes_next;
    logic [31:0]   fsum_reg, fsum_next;
    logic          op_reg, op_next;
    logic [31:0]   addr_reg, addr_next;
    logic [31:0]   size_reg, size_next;
    logic [63:0]   cur_reg, cur_next;       // entry k (upper neighbour)
    logic          cur_ok_reg, cur_ok_next; // k < used
    logic [CW-1:0] end_reg, end_next;       // shift bound
    logic [63:0]   hold_reg, hold_next;     // new entry for shift end
    logic [31:0]   res_addr_reg, res_addr_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic          mval_reg, mval_next;

    logic [31:0] in_size;
    logic [31:0] rs, rl;
    assign in_size = s_data.page_round ? ((s_data.region_size + ffca_pkg::PageAdd)
                                          & ffca_pkg::PageMask) : s_data.region_size;
    assign rs = rd_data[63:32];
    assign rl = rd_data[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ffca_pkg::ST_IDLE;
            used_reg   <= '0;
            peak_reg   <= '0;
            dcnt_reg   <= '0;
            dbytes_reg <= '0;
            fsum_reg   <= '0;
            mval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            peak_reg   <= peak_next;
            dcnt_reg   <= dcnt_next;
            dbytes_reg <= dbytes_next;
            fsum_reg   <= fsum_next;
            mval_reg   <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        size_reg     <= size_next;
        cur_reg      <= cur_next;
        cur_ok_reg   <= cur_ok_next;
        end_reg      <= end_next;
        hold_reg     <= hold_next;
        res_addr_reg <= res_addr_next;
        res_st_reg   <= res_st_next;
    end

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        used_next     = used_reg;
        peak_next     = peak_reg;
        dcnt_next     = dcnt_reg;
        dbytes_next   = dbytes_reg;
        fsum_next     = fsum_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        size_next     = size_reg;
        cur_next      = cur_reg;
        cur_ok_next   = cur_ok_reg;
        end_next      = end_reg;
        hold_next     = hold_reg;
        res_addr_next = res_addr_reg;
        res_st_next   = res_st_reg;
        mval_next     = mval_reg;
        rd_en   = 1'b0;
        rd_addr = idx_reg[IW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        wr_data = '0;
        s_ready = 1'b0;

        unique case (state_reg)
            ffca_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next       = s_data.opcode;
                    addr_next     = s_data.region_addr;
                    size_next     = in_size;
                    idx_next      = '0;
                    res_addr_next = '0;
                    res_st_next   = ffca_pkg::StOk;
                    state_next    = ffca_pkg::ST_SCAN_RD;
                end
            end
            ffca_pkg::ST_SCAN_RD: begin
                if (idx_reg < used_reg) begin
                    rd_en      = 1'b1;
                    state_next = ffca_pkg::ST_SCAN_CHK;
                end else if (op_reg == ffca_pkg::OpAlloc) begin
                    res_st_next = ffca_pkg::StNoFit;
                    state_next  = ffca_pkg::ST_RESP;
                end else begin
                    cur_ok_next = 1'b0;
                    if (idx_reg != '0) begin
                        rd_en      = 1'b1;
                        rd_addr    = IW'(idx_reg - CW'(1));
                        state_next = ffca_pkg::ST_PREV_CHK;
                    end else begin
                        state_next = ffca_pkg::ST_INS_RD;
                        hold_next  = {addr_reg, size_reg};
                        end_next   = used_reg;
                    end
                end
            end
            ffca_pkg::ST_SCAN_CHK: begin
                if (op_reg == ffca_pkg::OpAlloc) begin
                    if (rl >= size_reg) begin
                        res_addr_next = rs;
                        fsum_next     = fsum_reg - size_reg;
                        if (rl == size_reg) begin
                            used_next  = used_reg - CW'(1);
                            state_next = ffca_pkg::ST_DEL_RD;
                        end else begin
                            wr_en      = 1'b1;
                            wr_data    = {rs + size_reg, rl - size_reg};
                            state_next = ffca_pkg::ST_RESP;
                        end
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = ffca_pkg::ST_SCAN_RD;
                    end
                end else if (rs > addr_reg) begin
                    cur_next    = rd_data;
                    cur_ok_next = 1'b1;
                    if (idx_reg != '0) begin
                        rd_en      = 1'b1;
                        rd_addr    = IW'(idx_reg - CW'(1));
                        state_next = ffca_pkg::ST_PREV_CHK;
                    end else if (addr_reg + size_reg == rs) begin
                        wr_en      = 1'b1;
                        wr_data    = {addr_reg, rl + size_reg};
                        fsum_next  = fsum_reg + size_reg;
                        state_next = ffca_pkg::ST_RESP;
                    end else begin
                        hold_next  = {addr_reg, size_reg};
                        end_next   = used_reg;
                        state_next = ffca_pkg::ST_INS_RD;
                    end
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ffca_pkg::ST_SCAN_RD;
                end
            end
            ffca_pkg::ST_PREV_CHK: begin
                // rd_data holds entry k-1
                if (rs + rl == addr_reg) begin
                    fsum_next = fsum_reg + size_reg;
                    wr_addr   = IW'(idx_reg - CW'(1));
                    wr_en     = 1'b1;
                    if (cur_ok_reg && (addr_reg + size_reg == cur_reg[63:32])) begin
                        wr_data    = {rs, rl + size_reg + cur_reg[31:0]};
                        used_next  = used_reg - CW'(1);
                        state_next = ffca_pkg::ST_DEL_RD;
                    end else begin
                        wr_data    = {rs, rl + size_reg};
                        state_next = ffca_pkg::ST_RESP;
                    end
                end else if (cur_ok_reg && (addr_reg + size_reg == cur_reg[63:32])) begin
                    wr_en      = 1'b1;
                    wr_data    = {addr_reg, cur_reg[31:0] + size_reg};
                    fsum_next  = fsum_reg + size_reg;
                    state_next = ffca_pkg::ST_RESP;
                end else begin
                    hold_next  = {addr_reg, size_reg};
                    end_next   = used_reg;
                    state_next = ffca_pkg::ST_INS_RD;
                end
            end
            ffca_pkg::ST_DEL_RD: begin
                // move entry idx+1 to idx while idx < used
                if (idx_reg < used_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = IW'(idx_reg + CW'(1));
                    state_next = ffca_pkg::ST_DEL_WR;
                end else begin
                    state_next = ffca_pkg::ST_RESP;
                end
            end
            ffca_pkg::ST_DEL_WR: begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                idx_next   = idx_reg + CW'(1);
                state_next = ffca_pkg::ST_DEL_RD;
            end
            ffca_pkg::ST_INS_RD: begin
                // end_reg walks down from used to k, then the new entry lands
                if (used_reg == Full) begin
                    dcnt_next   = dcnt_reg + 32'd1;
                    dbytes_next = dbytes_reg + size_reg;
                    res_st_next = ffca_pkg::StLost;
                    state_next  = ffca_pkg::ST_RESP;
                end else if (end_reg > idx_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = IW'(end_reg - CW'(1));
                    state_next = ffca_pkg::ST_INS_WR;
                end else begin
                    wr_en      = 1'b1;
                    wr_data    = hold_reg;
                    used_next  = used_reg + CW'(1);
                    if (peak_reg < used_reg + CW'(1)) begin
                        peak_next = used_reg + CW'(1);
                    end
                    fsum_next  = fsum_reg + size_reg;
                    state_next = ffca_pkg::ST_RESP;
                end
            end
            ffca_pkg::ST_INS_WR: begin
                wr_en      = 1'b1;
                wr_addr    = end_reg[IW-1:0];
                wr_data    = rd_data;
                end_next   = end_reg - CW'(1);
                state_next = ffca_pkg::ST_INS_RD;
            end
            ffca_pkg::ST_RESP: begin
                if (!mval_reg || m_ready) begin
                    mval_next  = 1'b1;
                    state_next = ffca_pkg::ST_IDLE;
                end
            end
            default: state_next = ffca_pkg::ST_IDLE;
        endcase
        if (mval_reg && m_ready && state_reg != ffca_pkg::ST_RESP) begin
            mval_next = 1'b0;
        end
    end

    ffca_pkg::ffca_out_t out_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == ffca_pkg::ST_RESP && (!mval_reg || m_ready)) begin
            out_reg.alloc_addr   <= res_addr_reg;
            out_reg.status       <= res_st_reg;
            out_reg.free_total   <= fsum_reg;
            out_reg.entries_used <= 11'(used_reg);
            out_reg.peak_entries <= 11'(peak_reg);
            out_reg.lost_count   <= dcnt_reg;
            out_reg.lost_bytes   <= dbytes_reg;
        end
    end
    assign m_valid = mval_reg;
    assign m_data  = out_reg;

    `ASSERT_IMPL(a_used_bound, aclk, aresetn, 1'b1, used_reg <= Full)
    `ASSERT_IMPL(a_peak_ge_used, aclk, aresetn, 1'b1, peak_reg >= used_reg)
    `ASSERT_NEXT(a_accept_scan, aclk, aresetn, s_valid && s_ready,
                 state_reg == ffca_pkg::ST_SCAN_RD)
endmodule
